>>> rtl/rmst_pkg.sv
// Shared constants, types and the signed minimum for the range-minimum tree.
// Used by the top level and by the port checker; depends on nothing else.
`timescale 1ns / 1ps

package rmst_pkg;

  localparam int LEAF_W     = 10;
  localparam int LEAVES     = 1 << LEAF_W;
  localparam int ADDR_W     = LEAF_W + 1;
  localparam int NODE_DEPTH = 2 * LEAVES;
  localparam int DATA_W     = 32;
  localparam int OP_W       = 3;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t IDENTITY = word_t'(32'sh7FFF_FFFF);

  localparam logic [OP_W-1:0] OP_SET    = 3'd0;
  localparam logic [OP_W-1:0] OP_BUILD  = 3'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  function automatic word_t smin(input word_t a, input word_t b);
    return (a <= b) ? a : b;
  endfunction

endpackage

>>> rtl/rmst_node_ram.sv
// Node store: one write port and two read ports, read data registered.
// Generic; no package dependency.
`timescale 1ns / 1ps

module rmst_node_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/range_min_segment_tree.sv
// Top level of the range-minimum segment tree: sequencer around the node store.
// Depends on rmst_pkg and rmst_node_ram.
`timescale 1ns / 1ps

// A command word (op, index, right_index, value) is taken at a rising edge
// where start is high and busy is low. Ops 3 (range minimum) and 4 (read
// leaf) return one word on result, shown for exactly one cycle with done
// high; the receiver cannot hold it off. Other ops return nothing.
// Per op, as shaped by the single write port and the registered reads
// of the node store (two nodes read per access):
//   set leaf      busy stays low.
//   read leaf     busy in S_LEAF_OUT, done in the cycle after.
//   update leaf   leaf write in the cycle the word is taken, then busy
//                 while it reads the children and writes the parent
//                 once per level.
//   range minimum S_Q_RD and S_Q_ACC for each tree level walked, then a last S_Q_RD;
//                 done in the cycle busy falls.
//   build         children read and parent written for each inner node, 1023 down to 1.
//   unused ops    ignored, busy stays low.
// After reset a clearing pass writes the largest int to all 2048 nodes,
// one a cycle, holding busy high until it is done.

module range_min_segment_tree
  import rmst_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          op,
  input  logic [LEAF_W-1:0]        index,
  input  logic [LEAF_W-1:0]        right_index,
  input  logic signed [DATA_W-1:0] value,
  output logic signed [DATA_W-1:0] result,
  output logic                     done
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TREE_RD,
    S_TREE_WR,
    S_LEAF_OUT,
    S_Q_RD,
    S_Q_ACC
  } state_t;

  state_t              state;
  logic [ADDR_W-1:0]   clr_addr;
  logic [LEAF_W-1:0]   k;
  logic                is_build;
  logic [ADDR_W:0]     l;
  logic [ADDR_W:0]     r;
  word_t               acc_l;
  word_t               acc_r;

  logic [ADDR_W:0]     l_next;
  logic [ADDR_W:0]     r_next;
  word_t               acc_l_next;
  word_t               acc_r_next;

  logic                we;
  logic [ADDR_W-1:0]   waddr;
  word_t               wdata;
  logic [ADDR_W-1:0]   raddr_a;
  logic [ADDR_W-1:0]   raddr_b;
  word_t               rdata_a;
  word_t               rdata_b;

  logic                accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // A write and a read of one node can fall in the same cycle, but that read is never
  // used: every write is followed by a fresh read cycle, so no forwarding is needed.
  rmst_node_ram #(
    .DEPTH(NODE_DEPTH),
    .WIDTH(DATA_W)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  always_comb begin
    we      = 1'b0;
    waddr   = {1'b1, index};
    wdata   = value;
    raddr_a = {1'b1, index};
    raddr_b = {1'b1, index};
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = IDENTITY;
      end
      S_IDLE: begin
        we = accept && (op == OP_SET || op == OP_UPDATE);
      end
      S_TREE_RD: begin
        raddr_a = {k, 1'b0};
        raddr_b = {k, 1'b1};
      end
      S_TREE_WR: begin
        we    = 1'b1;
        waddr = {1'b0, k};
        wdata = smin(rdata_a, rdata_b);
      end
      S_Q_RD: begin
        raddr_a = l[ADDR_W-1:0];
        raddr_b = r[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // One level of the bottom-up walk: an odd left end and an even right end
  // are taken into their accumulators and stepped inwards before halving.
  always_comb begin
    l_next     = l;
    r_next     = r;
    acc_l_next = acc_l;
    acc_r_next = acc_r;
    if (l[0]) begin
      acc_l_next = smin(acc_l, rdata_a);
      l_next     = l + 1'b1;
    end
    if (!r[0]) begin
      acc_r_next = smin(rdata_b, acc_r);
      r_next     = r - 1'b1;
    end
    l_next = l_next >> 1;
    r_next = r_next >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(NODE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (op)
              OP_BUILD: begin
                k        <= '1;
                is_build <= 1'b1;
                state    <= S_TREE_RD;
              end
              OP_UPDATE: begin
                k        <= {1'b1, index[LEAF_W-1:1]};
                is_build <= 1'b0;
                state    <= S_TREE_RD;
              end
              OP_QUERY: begin
                l     <= {2'b01, index};
                r     <= {2'b01, right_index};
                acc_l <= IDENTITY;
                acc_r <= IDENTITY;
                state <= S_Q_RD;
              end
              OP_READ: begin
                state <= S_LEAF_OUT;
              end
              default: begin
              end
            endcase
          end
        end
        S_TREE_RD: begin
          state <= S_TREE_WR;
        end
        S_TREE_WR: begin
          if (k == LEAF_W'(1)) begin
            state <= S_IDLE;
          end else begin
            k     <= is_build ? k - 1'b1 : k >> 1;
            state <= S_TREE_RD;
          end
        end
        S_LEAF_OUT: begin
          result <= rdata_a;
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_Q_RD: begin
          if (l <= r) begin
            state <= S_Q_ACC;
          end else begin
            result <= smin(acc_l, acc_r);
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_Q_ACC: begin
          l     <= l_next;
          r     <= r_next;
          acc_l <= acc_l_next;
          acc_r <= acc_r_next;
          state <= S_Q_RD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/rmst_checker.sv
// Port-level checks for the range-minimum tree, bound to the top level.
// Depends on rmst_pkg and range_min_segment_tree.
`timescale 1ns / 1ps

module rmst_checker
  import rmst_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic [OP_W-1:0] op,
  input logic            done
);

  // The clearing pass must hold the block off as soon as reset is released.
  a_busy_after_reset: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> busy)
    else $error("busy low on leaving reset");

  // A result word always follows a busy period.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without preceding busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done high for two cycles");

  // Setting a leaf completes in the cycle it is taken.
  a_set_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_SET) |=> !busy)
    else $error("busy after set leaf");

  a_work_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op == OP_QUERY || op == OP_READ || op == OP_BUILD ||
      op == OP_UPDATE)) |=> busy)
    else $error("busy low after a multi-cycle command");

endmodule

bind range_min_segment_tree rmst_checker u_rmst_checker (.*);

>>> test/rmst_tree_checker.sv
// Checker for the range-minimum segment tree: watches the command and result
// ports, keeps its own copy of the node store and compares every result word.
// Depends on rmst_pkg for widths, op codes and the identity value.
`timescale 1ns / 1ps

module rmst_tree_checker
  import rmst_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [OP_W-1:0]   op,
  input  logic [LEAF_W-1:0] index,
  input  logic [LEAF_W-1:0] right_index,
  input  word_t             value,
  input  word_t             result,
  input  logic              done,
  output int                failures,
  output int                pending
);

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [LEAF_W-1:0] lo;
    logic [LEAF_W-1:0] hi;
    word_t             min_val;
  } answer_t;

  // Node 1 is the root, node k has children 2k and 2k+1, leaf i sits at LEAVES+i.
  word_t   tree_copy [NODE_DEPTH];
  answer_t awaited_mins [$];
  answer_t oldest;
  answer_t fresh;
  int      node;

  function automatic word_t lesser(input word_t a, input word_t b);
    return (b < a) ? b : a;
  endfunction

  function automatic word_t span_min(input logic [LEAF_W-1:0] lo,
                                     input logic [LEAF_W-1:0] hi);
    int unsigned l;
    int unsigned r;
    word_t       left_acc;
    word_t       right_acc;
    l         = lo + LEAVES;
    r         = hi + LEAVES;
    left_acc  = IDENTITY;
    right_acc = IDENTITY;
    while (l <= r) begin
      if (l[0]) begin
        left_acc = lesser(left_acc, tree_copy[l]);
        l++;
      end
      if (!r[0]) begin
        right_acc = lesser(tree_copy[r], right_acc);
        r--;
      end
      l = l >> 1;
      r = r >> 1;
    end
    return lesser(left_acc, right_acc);
  endfunction

  task automatic report_mismatch(input string msg);
    if (failures < 20)
      $display("MISMATCH at %0t ns: %s", $time, msg);
    failures = failures + 1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      failures = 0;
      foreach (tree_copy[k])
        tree_copy[k] = IDENTITY;
      awaited_mins.delete();
    end else begin
      // A result word always belongs to a command taken at an earlier edge.
      if (done) begin
        if (awaited_mins.size() == 0) begin
          report_mismatch($sformatf("result %0d with no word awaited", result));
        end else begin
          oldest = awaited_mins.pop_front();
          if (result !== oldest.min_val)
            report_mismatch($sformatf("op %0d index %0d right %0d: result %0d, wanted %0d",
                                      oldest.op, oldest.lo, oldest.hi, result,
                                      oldest.min_val));
        end
      end

      if (start && !busy) begin
        fresh.op      = op;
        fresh.lo      = index;
        fresh.hi      = right_index;
        fresh.min_val = IDENTITY;
        case (op)
          OP_SET: begin
            tree_copy[LEAVES + index] = value;
          end
          OP_BUILD: begin
            for (int k = LEAVES - 1; k >= 1; k--)
              tree_copy[k] = lesser(tree_copy[2 * k], tree_copy[2 * k + 1]);
          end
          OP_UPDATE: begin
            node            = LEAVES + index;
            tree_copy[node] = value;
            node            = node >> 1;
            while (node >= 1) begin
              tree_copy[node] = lesser(tree_copy[2 * node], tree_copy[2 * node + 1]);
              node            = node >> 1;
            end
          end
          OP_QUERY: begin
            fresh.min_val = span_min(index, right_index);
            awaited_mins.push_back(fresh);
          end
          OP_READ: begin
            fresh.min_val = tree_copy[LEAVES + index];
            awaited_mins.push_back(fresh);
          end
          default: begin
          end
        endcase
      end
    end
    pending <= awaited_mins.size();
  end

endmodule

>>> test/tb.sv
// Testbench top for the range-minimum segment tree: clock, reset, command
// stimulus and the final verdict. Depends on rmst_pkg, the block under test
// and rmst_tree_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb;
  import rmst_pkg::*;

  localparam word_t MOST_NEG    = word_t'(32'sh8000_0000);
  localparam int    PHASE_WORDS = 170;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [OP_W-1:0]   op;
  logic [LEAF_W-1:0] index;
  logic [LEAF_W-1:0] right_index;
  word_t             value;
  word_t             result;
  logic              done;
  int                failures;
  int                pending;
  int                idle_pct;

  range_min_segment_tree u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .index       (index),
    .right_index (right_index),
    .value       (value),
    .result      (result),
    .done        (done)
  );

  rmst_tree_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .index       (index),
    .right_index (right_index),
    .value       (value),
    .result      (result),
    .done        (done),
    .failures    (failures),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("range_min_segment_tree test failed");
    $finish;
  end

  // Holds start high from the edge it is raised until the word is taken.
  task automatic send_word(input logic [OP_W-1:0] o, input logic [LEAF_W-1:0] lo,
                           input logic [LEAF_W-1:0] hi, input word_t v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    op          <= o;
    index       <= lo;
    right_index <= hi;
    value       <= v;
    @(posedge clk);
    while (busy)
      @(posedge clk);
  endtask

  // Most leaves come from two narrow windows so that writes and reads meet.
  function automatic logic [LEAF_W-1:0] pick_leaf();
    int p;
    p = $urandom_range(99);
    if (p < 40)
      return LEAF_W'($urandom_range(15));
    if (p < 50)
      return LEAF_W'($urandom_range(LEAVES - 1, LEAVES - 16));
    return LEAF_W'($urandom_range(LEAVES - 1));
  endfunction

  function automatic word_t pick_value();
    int p;
    p = $urandom_range(99);
    if (p < 5)
      return IDENTITY;
    if (p < 10)
      return MOST_NEG;
    if (p < 15)
      return '0;
    if (p < 20)
      return '1;
    if (p < 40)
      return word_t'($signed($urandom_range(200)) - 100);
    return word_t'($urandom);
  endfunction

  task automatic random_word(output bit ignored);
    logic [OP_W-1:0]   o;
    logic [LEAF_W-1:0] a;
    logic [LEAF_W-1:0] b;
    logic [LEAF_W-1:0] t;
    int                pick;
    int                shape;
    pick = $urandom_range(99);
    a    = pick_leaf();
    b    = pick_leaf();
    if (pick < 15)
      o = OP_SET;
    else if (pick < 17)
      o = OP_BUILD;
    else if (pick < 47)
      o = OP_UPDATE;
    else if (pick < 82)
      o = OP_QUERY;
    else if (pick < 95)
      o = OP_READ;
    else
      o = OP_W'($urandom_range((1 << OP_W) - 1, OP_READ + 1));
    if (o == OP_QUERY) begin
      shape = $urandom_range(9);
      if (shape == 0) begin
        // Empty range: left end strictly above the right end.
        a = LEAF_W'($urandom_range(LEAVES - 1, 1));
        b = LEAF_W'($urandom_range(a - 1, 0));
      end else if (shape <= 3) begin
        b = (a > LEAVES - 17) ? LEAF_W'(LEAVES - 1) : LEAF_W'(a + $urandom_range(16));
      end else if (shape == 4) begin
        if ($urandom_range(1))
          a = '0;
        else
          b = '1;
      end else if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
    end
    send_word(o, a, b, pick_value());
    ignored = (o > OP_READ);
  endtask

  initial begin
    int  idle_plan [3];
    int  sent;
    bit  skip;
    idle_plan = '{29, 58, 0};
    idle_pct  = idle_plan[0];
    rst         <= 1'b1;
    start       <= 1'b0;
    op          <= OP_SET;
    index       <= '0;
    right_index <= '0;
    value       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: cleared store, extreme leaves and values, empty range,
    // a leaf set without rebuilding, then a build and the unused op codes.
    send_word(OP_READ,   10'd0,    10'd0,    '0);
    send_word(OP_QUERY,  10'd0,    10'd1023, '0);
    send_word(OP_UPDATE, 10'd0,    10'd0,    MOST_NEG);
    send_word(OP_UPDATE, 10'd1023, 10'd0,    IDENTITY);
    send_word(OP_UPDATE, 10'd512,  10'd0,    '0);
    send_word(OP_UPDATE, 10'd341,  10'd682,  word_t'(32'h5555_5555));
    send_word(OP_UPDATE, 10'd682,  10'd341,  word_t'(32'hAAAA_AAAA));
    send_word(OP_QUERY,  10'd0,    10'd1023, '0);
    send_word(OP_QUERY,  10'd1,    10'd1023, '0);
    send_word(OP_QUERY,  10'd1023, 10'd1023, '0);
    send_word(OP_QUERY,  10'd600,  10'd3,    '0);
    send_word(OP_QUERY,  10'd512,  10'd512,  '0);
    send_word(OP_SET,    10'd7,    10'd0,    '1);
    send_word(OP_QUERY,  10'd1,    10'd1023, '0);
    send_word(OP_QUERY,  10'd7,    10'd7,    '0);
    send_word(OP_READ,   10'd7,    10'd0,    '0);
    send_word(OP_BUILD,  10'd0,    10'd0,    '0);
    send_word(OP_QUERY,  10'd1,    10'd1022, '0);
    send_word(OP_READ,   10'd1023, 10'd0,    '0);
    for (int u = OP_READ + 1; u < (1 << OP_W); u++)
      send_word(OP_W'(u), pick_leaf(), pick_leaf(), pick_value());
    send_word(OP_READ,   10'd341,  10'd0,    '0);

    foreach (idle_plan[ph]) begin
      idle_pct = idle_plan[ph];
      sent     = 0;
      while (sent < PHASE_WORDS) begin
        random_word(skip);
        if (!skip)
          sent++;
      end
      if (ph == 0) begin
        // Let the tree drain completely before carrying on.
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    while (busy)
      @(posedge clk);
    repeat (30) @(posedge clk);
    if (failures == 0 && pending == 0)
      $display("range_min_segment_tree test passed");
    else
      $display("range_min_segment_tree test failed");
    $finish;
  end

endmodule
